FILE: hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_SHIFT_BACK  = 2'd1,
    CELL_SHIFT_FRONT = 2'd2,
    CELL_LOAD_BACK   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at_back;
  } cell_ctrl_t;

  localparam int ITEM_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int POP_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int OUT_W    = 40;

endpackage

FILE: hw/rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue chain; shifts with its neighbors or loads.
// ----------------------------------------------------------------------------
module dq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  dq_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]  left,
  input  logic [DATA_WIDTH-1:0]  right,
  input  logic [DATA_WIDTH-1:0]  push_word,
  output logic [DATA_WIDTH-1:0]  word
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dq_pkg::CELL_SHIFT_BACK: begin
        word <= left;
      end
      dq_pkg::CELL_SHIFT_FRONT: begin
        word <= right;
      end
      dq_pkg::CELL_LOAD_BACK: begin
        if (ctrl.at_back) begin
          word <= push_word;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of data words held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Input channel (s_*): one operation per transfer; s_tuser selects push
// front, push back, pop front or pop back, s_tdata carries the word to push.
// Output channel (m_*): one result per operation with the popped word, a
// status code and the occupancy after the operation.
// The front word always sits in cell 0; a front push shifts the chain back
// one cell, a front pop shifts it forward, a back push loads the cell at the
// current count and a back pop reads the cell below it.
// The result is registered and becomes valid in the cycle after the input
// transfer. The unit takes one operation per cycle while results are taken.
// When the receiver stalls, the held result blocks the next input until it
// is taken. Reset empties the queue and clears the output valid; cell
// contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [dq_pkg::ITEM_W-1:0] s_tdata,   // [31:0] item_value
  input  logic [dq_pkg::FUNC_W-1:0] s_tuser,   // [1:0] func
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [dq_pkg::OUT_W-1:0]  m_tdata    // [31:0] popped_value,
                                               // [33:32] status,
                                               // [38:34] occupancy, [39] zero
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      count_m1;
  logic                  accept;
  logic                  full;
  logic                  empty;
  dq_pkg::func_t         func;
  dq_pkg::status_t       status;
  dq_pkg::cell_op_t      cmd;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] popped;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [63:0]           in_ext;
  logic [63:0]           pop_ext;
  logic [15:0]           cnt_ext;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign func     = dq_pkg::func_t'(s_tuser);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - CNT_W'(1);

  assign in_ext    = {32'b0, s_tdata};
  assign push_word = in_ext[DATA_WIDTH-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      dq_pkg::cell_ctrl_t    ctrl;
      logic [DATA_WIDTH-1:0] left;
      logic [DATA_WIDTH-1:0] right;

      assign ctrl.op      = cmd;
      assign ctrl.at_back = (count == CNT_W'(gi));

      if (gi == 0) begin : g_first
        assign left = push_word;
      end else begin : g_mid_l
        assign left = cell_q[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_q[gi+1];
      end

      dq_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .left      (left),
        .right     (right),
        .push_word (push_word),
        .word      (cell_q[gi])
      );
    end
  endgenerate

  // back word: one-hot select by count - 1
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_m1 == CNT_W'(i)) begin
        back_word = back_word | cell_q[i];
      end
    end
  end

  always_comb begin
    cmd        = dq_pkg::CELL_HOLD;
    status     = dq_pkg::ST_OK;
    count_next = count;
    popped     = '0;
    case (func)
      dq_pkg::FUNC_PUSH_FRONT, dq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          cmd        = (func == dq_pkg::FUNC_PUSH_FRONT) ? dq_pkg::CELL_SHIFT_BACK
                                                         : dq_pkg::CELL_LOAD_BACK;
          count_next = count + CNT_W'(1);
        end
      end
      dq_pkg::FUNC_POP_FRONT, dq_pkg::FUNC_POP_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          count_next = count_m1;
          if (func == dq_pkg::FUNC_POP_FRONT) begin
            cmd    = dq_pkg::CELL_SHIFT_FRONT;
            popped = cell_q[0];
          end else begin
            popped = back_word;
          end
        end
      end
      default: begin
        cmd = dq_pkg::CELL_HOLD;
      end
    endcase
    if (!accept) begin
      cmd = dq_pkg::CELL_HOLD;
    end
  end

  assign pop_ext = 64'(popped);
  assign cnt_ext = 16'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (s_tready) begin
        m_tvalid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, cnt_ext[dq_pkg::OCC_W-1:0], status, pop_ext[dq_pkg::POP_W-1:0]};
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_full_push_holds : assert property (@(posedge clk) disable iff (rst)
    accept && full && (func == dq_pkg::FUNC_PUSH_FRONT || func == dq_pkg::FUNC_PUSH_BACK)
    |=> count == $past(count))
    else $error("push on full queue changed count");

  a_pop_decrements : assert property (@(posedge clk) disable iff (rst)
    accept && !empty && (func == dq_pkg::FUNC_POP_FRONT || func == dq_pkg::FUNC_POP_BACK)
    |=> count == $past(count_m1))
    else $error("pop did not decrement count");

  a_front_push_lands : assert property (@(posedge clk) disable iff (rst)
    accept && !full && func == dq_pkg::FUNC_PUSH_FRONT
    |=> cell_q[0] == $past(push_word))
    else $error("front push word not at head cell");

endmodule
